>>> design/sdat_pkg.sv
// types, constants and divide-by-constant helpers for the step detector
package sdat_pkg;

   localparam int HistDepth = 7;
   localparam int SampleWidth = 16;
   localparam int SumWidth = 20;
   localparam int NumWidth = 19;
   localparam int TsWidth = 32;

   localparam logic signed [15:0] OneG = 16'sd4096;
   localparam logic signed [15:0] SampleMax = 16'sh7fff;
   localparam logic signed [15:0] SampleMin = 16'sh8000;

   localparam logic [15:0] MinStepReset = 16'd200;
   localparam logic [15:0] MaxStepReset = 16'd2000;
   localparam logic [14:0] FloorReset = 15'd4096;

   // ceil(2^22 / 9) and ceil(2^20 / 5)
   localparam logic [18:0] Div9Recip = 19'd466034;
   localparam logic [17:0] Div5Recip = 18'd209716;

   typedef enum logic [1:0] {
      REG_MIN_STEP = 2'd0,
      REG_MAX_STEP = 2'd1,
      REG_FLOOR    = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [15:0] min_step_ms;
      logic [15:0] max_step_ms;
      logic [14:0] threshold_floor;
   } cfg_type;

   typedef struct packed {
      logic                         win_end;
      logic signed [NumWidth-1:0]   num;
   } win_type;

   typedef struct packed {
      logic [TsWidth-1:0]           ts;
      logic signed [SumWidth-1:0]   sum;
      logic                         win_end;
      logic signed [NumWidth-1:0]   num;
   } stage_type;

   // truncating divide by 9, magnitude below 2^21
   function automatic logic signed [15:0] div9_trunc(input logic signed [SumWidth-1:0] v);
      logic [SumWidth-1:0] mag;
      logic [38:0]         prod;
      logic [15:0]         q;
      mag = v[SumWidth-1] ? SumWidth'(-v) : SumWidth'(v);
      prod = 39'(mag) * 39'(Div9Recip);
      q = prod[37:22];
      return v[SumWidth-1] ? $signed(16'(16'd0 - q)) : $signed(q);
   endfunction

   // truncating divide by 5, magnitude below 2^18
   function automatic logic signed [15:0] div5_trunc(input logic signed [NumWidth-1:0] v);
      logic [NumWidth-1:0] mag;
      logic [35:0]         prod;
      logic [15:0]         q;
      mag = v[NumWidth-1] ? NumWidth'(-v) : NumWidth'(v);
      prod = 36'(mag) * 36'(Div5Recip);
      q = prod[35:20];
      return v[NumWidth-1] ? $signed(16'(16'd0 - q)) : $signed(q);
   endfunction

endpackage

>>> design/step_detect_adaptive_threshold.sv
// step detector: smoothing, windowed adaptive threshold and crossing timing
// a word waits in the input register until the output is free, then rsp_tvalid rises
// throughput: one word per cycle unless the output stalls; the input and result registers are
//   the only stages, the threshold and smoothing use constant-reciprocal multiplies
// reset clears history to 1 g, threshold to the floor reset value and all handshakes;
// other registers return to their reset values on reset, except s1_ff and step_ff
module step_detect_adaptive_threshold
   import sdat_pkg::*;
#(
   parameter int WINDOW_LEN = 150
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // accel_sample[15:0], timestamp_ms[47:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // step_detected[0], zero fill
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type   cfg;
   win_type   win;
   stage_type s1_ff;
   stage_type s1_in;

   logic signed [SampleWidth-1:0] sample;
   logic [TsWidth-1:0]            ts;
   logic signed [SampleWidth-1:0] hist_ff [HistDepth];
   logic signed [SumWidth-1:0]    sum_in;

   logic                          s1_valid_ff;
   logic                          rsp_valid_ff;
   logic                          out_load;
   logic                          s1_adv;
   logic                          accept;

   logic signed [15:0]            thr_ff;
   logic signed [15:0]            thr_cand;
   logic signed [15:0]            thr_div;
   logic signed [15:0]            thr_in;
   logic signed [15:0]            floor_s;
   logic signed [15:0]            filt_in;
   logic signed [15:0]            last_filt_ff;
   logic [TsWidth-1:0]            rise_ff;
   logic [TsWidth-1:0]            rise_in;
   logic [TsWidth-1:0]            dt;
   logic                          rise;
   logic                          fall;
   logic                          step_ff;
   logic                          step_in;

   sdat_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdat_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .sample  (sample),
      .win     (win)
   );

   assign sample = $signed(req_tdata[15:0]);
   assign ts = req_tdata[47:16];

   assign out_load = !rsp_valid_ff || rsp_tready;
   assign s1_adv = s1_valid_ff && out_load;
   assign req_tready = !s1_valid_ff || out_load;
   assign accept = req_tvalid && req_tready;

   // twice the new sample plus the seven previous ones
   always_comb begin
      sum_in = SumWidth'(2 * SumWidth'(sample));
      for (int k = 0; k < HistDepth; k++) begin
         sum_in = sum_in + SumWidth'(hist_ff[k]);
      end
      s1_in.ts = ts;
      s1_in.sum = sum_in;
      s1_in.win_end = win.win_end;
      s1_in.num = win.num;
   end

   always_comb begin
      floor_s = $signed({1'b0, cfg.threshold_floor});
      thr_div = div5_trunc(s1_ff.num);
      thr_cand = (thr_div < floor_s) ? floor_s : thr_div;
      thr_in = s1_ff.win_end ? thr_cand : thr_ff;
      filt_in = div9_trunc(s1_ff.sum);
      rise = (last_filt_ff < thr_in) && (filt_in > thr_in);
      fall = (last_filt_ff > thr_in) && (filt_in < thr_in);
      rise_in = rise ? s1_ff.ts : rise_ff;
      dt = s1_ff.ts - rise_ff;
      step_in = fall && (dt >= TsWidth'(cfg.min_step_ms)) && (dt <= TsWidth'(cfg.max_step_ms));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff <= $signed({1'b0, FloorReset});
         last_filt_ff <= OneG;
         rise_ff <= '0;
         for (int k = 0; k < HistDepth; k++) begin
            hist_ff[k] <= OneG;
         end
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            hist_ff[0] <= sample;
            for (int k = 1; k < HistDepth; k++) begin
               hist_ff[k] <= hist_ff[k-1];
            end
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            thr_ff <= thr_in;
            last_filt_ff <= filt_in;
            rise_ff <= rise_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         step_ff <= step_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, step_ff};

   a_thr_floor: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_ff.win_end |=> thr_ff >= $signed({1'b0, $past(cfg.threshold_floor)}))
      else $error("threshold below floor after window end");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(rise_ff) && $stable(last_filt_ff) && $stable(thr_ff))
      else $error("crossing state changed without an item");

   a_stage_keep: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_load |=> s1_valid_ff && $stable(s1_ff))
      else $error("held word lost from input stage");

endmodule

>>> design/sdat_csr.sv
// apb register file for step interval limits and threshold floor
module sdat_csr
   import sdat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   reg_idx_type idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign idx = reg_idx_type'(csr_paddr[3:2]);
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_MIN_STEP: cfg_in.min_step_ms = csr_pwdata[15:0];
            REG_MAX_STEP: cfg_in.max_step_ms = csr_pwdata[15:0];
            REG_FLOOR:    cfg_in.threshold_floor = csr_pwdata[14:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MIN_STEP: csr_prdata = {16'd0, cfg_ff.min_step_ms};
         REG_MAX_STEP: csr_prdata = {16'd0, cfg_ff.max_step_ms};
         REG_FLOOR:    csr_prdata = {17'd0, cfg_ff.threshold_floor};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_step_ms <= MinStepReset;
         cfg_ff.max_step_ms <= MaxStepReset;
         cfg_ff.threshold_floor <= FloorReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/sdat_window.sv
// running min and max of raw samples over a window, threshold numerator at window end
module sdat_window
   import sdat_pkg::*;
#(
   parameter int WINDOW_LEN = 150
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic signed [SampleWidth-1:0] sample,
   output win_type                       win
);

   localparam int CountWidth = $clog2(WINDOW_LEN + 1);

   logic [CountWidth-1:0]         count_ff;
   logic [CountWidth-1:0]         count_in;
   logic [CountWidth-1:0]         count_inc;
   logic signed [SampleWidth-1:0] min_ff;
   logic signed [SampleWidth-1:0] min_in;
   logic signed [SampleWidth-1:0] max_ff;
   logic signed [SampleWidth-1:0] max_in;
   logic signed [SampleWidth-1:0] min_new;
   logic signed [SampleWidth-1:0] max_new;

   always_comb begin
      min_new = (sample < min_ff) ? sample : min_ff;
      max_new = (sample > max_ff) ? sample : max_ff;
      count_inc = count_ff + CountWidth'(1);
      win.win_end = (count_inc >= CountWidth'(WINDOW_LEN));
      win.num = NumWidth'(3 * NumWidth'(min_new) + 2 * NumWidth'(max_new));
      if (win.win_end) begin
         count_in = '0;
         min_in = SampleMax;
         max_in = SampleMin;
      end else begin
         count_in = count_inc;
         min_in = min_new;
         max_in = max_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff <= SampleMax;
         max_ff <= SampleMin;
      end else if (advance) begin
         count_ff <= count_in;
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

endmodule
